/* rtl/gtg_pkg.sv */
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the go-to-goal velocity block.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int CordicSteps = 16;
    localparam int DiffW       = 17;   // goal minus position
    localparam int D2W         = 34;   // squared distance
    localparam int DistW       = 17;   // integer root of d2
    localparam int CordW       = 28;   // CORDIC x/y width (scaled by 256)
    localparam int AngW        = 21;   // angle in 2^-16 rad

    localparam logic [D2W-1:0]  NearD2    = D2W'(41943);
    localparam logic [AngW-1:0] TurnMin   = AngW'(13107);
    localparam logic [AngW-1:0] PiHalfQ16 = AngW'(102944);

    // Register indexes
    localparam logic [1:0] RegGoalX      = 2'd0;
    localparam logic [1:0] RegGoalY      = 2'd1;
    localparam logic [1:0] RegSpeedGain  = 2'd2;
    localparam logic [1:0] RegSpeedLimit = 2'd3;

    // Arctangent table, 2^-16 rad
    function automatic logic [AngW-1:0] atan_lut(input logic [3:0] idx);
        logic [AngW-1:0] v;
        unique case (idx)
            4'd0:    v = AngW'(51472);
            4'd1:    v = AngW'(30386);
            4'd2:    v = AngW'(16055);
            4'd3:    v = AngW'(8150);
            4'd4:    v = AngW'(4091);
            4'd5:    v = AngW'(2047);
            4'd6:    v = AngW'(1024);
            4'd7:    v = AngW'(512);
            4'd8:    v = AngW'(256);
            4'd9:    v = AngW'(128);
            4'd10:   v = AngW'(64);
            4'd11:   v = AngW'(32);
            4'd12:   v = AngW'(16);
            4'd13:   v = AngW'(8);
            4'd14:   v = AngW'(4);
            default: v = AngW'(2);
        endcase
        return v;
    endfunction

    // Side-band that travels with an item through the pipeline
    typedef struct packed {
        logic                    zero;
        logic signed [AngW-1:0]  head8;
        logic        [D2W-1:0]   d2;
    } gtg_side_t;

endpackage

/* rtl/gtg_cordic.sv */
// ----------------------------------------------------------------------------
// gtg_cordic
// Pipelined CORDIC vectoring atan2, one iteration per stage, plus quadrant
// pre-rotation stage. Advances on en.
// ----------------------------------------------------------------------------
module gtg_cordic
    import gtg_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [DiffW-1:0]   dx,
    input  logic signed [DiffW-1:0]   dy,
    output logic signed [AngW-1:0]    angle
);

    logic signed [CordW-1:0] x_reg [0:CordicSteps];
    logic signed [CordW-1:0] y_reg [0:CordicSteps];
    logic signed [AngW-1:0]  z_reg [0:CordicSteps];

    logic signed [CordW-1:0] xs, ys;

    // Quadrant pre-rotation
    always_comb
    begin
        xs = CordW'(dx) <<< 8;
        ys = CordW'(dy) <<< 8;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_reg[0] <= ys;
                    y_reg[0] <= -xs;
                    z_reg[0] <= PiHalfQ16;
                end
                else
                begin
                    x_reg[0] <= -ys;
                    y_reg[0] <= xs;
                    z_reg[0] <= -PiHalfQ16;
                end
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    // Vectoring iterations
    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_iter
        logic signed [CordW-1:0] xsh, ysh;
        assign xsh = x_reg[i] >>> i;
        assign ysh = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ysh;
                    y_reg[i+1] <= y_reg[i] - xsh;
                    z_reg[i+1] <= z_reg[i] + atan_lut(4'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ysh;
                    y_reg[i+1] <= y_reg[i] + xsh;
                    z_reg[i+1] <= z_reg[i] - atan_lut(4'(i));
                end
            end
        end
    end

    assign angle = z_reg[CordicSteps];

endmodule

/* rtl/gtg_isqrt.sv */
// ----------------------------------------------------------------------------
// gtg_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// Advances on en.
// ----------------------------------------------------------------------------
module gtg_isqrt
    import gtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [D2W-1:0]       d2,
    output logic [DistW-1:0]     root
);

    localparam int RemW = DistW + 2;

    logic [D2W-1:0]   n_reg [0:DistW];
    logic [RemW-1:0]  r_reg [0:DistW];
    logic [DistW-1:0] q_reg [0:DistW];

    always_comb
    begin
        n_reg[0] = d2;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    // One bit per stage: bring down two bits, try 4q+1
    for (genvar i = 0; i < DistW; i++)
    begin : g_bit
        logic [RemW-1:0] rem_w, trial;
        assign rem_w = {r_reg[i][RemW-3:0], n_reg[i][D2W-1:D2W-2]};
        assign trial = {q_reg[i][RemW-3:0], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1] <= n_reg[i] << 2;
                if (rem_w >= trial)
                begin
                    r_reg[i+1] <= rem_w - trial;
                    q_reg[i+1] <= {q_reg[i][DistW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i+1] <= rem_w;
                    q_reg[i+1] <= {q_reg[i][DistW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = q_reg[DistW];

endmodule

/* rtl/go_to_goal_velocity.sv */
// ----------------------------------------------------------------------------
// go_to_goal_velocity
// Proportional go-to-goal controller: pose item in, speed and turn item out.
// ----------------------------------------------------------------------------
// Accepts one pose item per clock. There are 22 register stages from an
// accepted pose item to its result in the output register. The stages are
// one input stage for the differences, one for the squares, one for the sum,
// the 17-stage root pipeline, one stage for the error and gain product, and
// the output register. The CORDIC atan2 runs alongside in 17 stages fed from
// the differences, and its angle waits in bearing_reg for the root. The
// whole pipeline stalls together when the output is held, so throughput is
// one item per cycle while the consumer takes items.
module go_to_goal_velocity
    import gtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   pos_x,
    input  logic signed [15:0]   pos_y,
    input  logic signed [15:0]   heading,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [14:0]          fwd_speed,
    output logic [14:0]          turn_rate
);

    localparam int Depth = DistW + 5; // valid stages up to the output

    logic [14:0] goal_x_reg, goal_y_reg, speed_limit_reg;
    logic [15:0] speed_gain_reg;
    logic        en;
    logic [Depth-1:0] vld_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= 15'd2048;
            goal_y_reg      <= 15'd2048;
            speed_gain_reg  <= 16'd4096;
            speed_limit_reg <= 15'd6144;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegGoalX:      goal_x_reg      <= cfg_data[14:0];
                RegGoalY:      goal_y_reg      <= cfg_data[14:0];
                RegSpeedGain:  speed_gain_reg  <= cfg_data;
                RegSpeedLimit: speed_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Global stall: advance unless the output holds an untaken item
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
    end

    // Stage 1: differences
    logic signed [DiffW-1:0] dx_reg, dy_reg;
    logic signed [AngW-1:0]  head8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= $signed({2'b00, goal_x_reg}) - DiffW'(pos_x);
            dy_reg    <= $signed({2'b00, goal_y_reg}) - DiffW'(pos_y);
            head8_reg <= AngW'(heading) <<< 3;
        end
    end

    // Stage 2: squares
    logic [D2W-2:0]        sx_reg, sy_reg;
    gtg_side_t             s2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg       <= (D2W-1)'(dx_reg * dx_reg);
            sy_reg       <= (D2W-1)'(dy_reg * dy_reg);
            s2_reg.head8 <= head8_reg;
            s2_reg.zero  <= (dx_reg == '0) && (dy_reg == '0);
            s2_reg.d2    <= '0;
        end
    end

    // Stage 3: sum
    gtg_side_t s3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg       <= s2_reg;
            s3_reg.d2    <= D2W'(sx_reg) + D2W'(sy_reg);
        end
    end

    // Root (DistW stages) and CORDIC (CordicSteps+1 stages), CORDIC from stage 1
    logic [DistW-1:0]       dist_root;
    logic signed [AngW-1:0] bearing;
    logic signed [AngW-1:0] bearing_reg [0:1];

    gtg_isqrt u_isqrt (.clk(clk), .en(en), .d2(s3_reg.d2), .root(dist_root));
    gtg_cordic u_cordic (.clk(clk), .en(en), .dx(dx_reg), .dy(dy_reg), .angle(bearing));

    // Side-band delay across the root pipeline
    gtg_side_t side_reg [0:DistW-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s3_reg;
            for (int k = 1; k < DistW; k++)
                side_reg[k] <= side_reg[k-1];
            bearing_reg[0] <= bearing;
            bearing_reg[1] <= bearing_reg[0];
        end
    end

    // Stage E: bearing error and gain product
    gtg_side_t              se;
    logic signed [AngW-1:0] err;
    logic [AngW-1:0]        mag_reg;
    logic [32:0]            prod_reg;
    gtg_side_t              e_reg;
    assign se  = side_reg[DistW-1];
    assign err = (se.zero ? '0 : bearing_reg[1]) - se.head8;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= err[AngW-1] ? AngW'(-err) : AngW'(err);
            prod_reg <= speed_gain_reg * dist_root;
            e_reg    <= se;
        end
    end

    // Output stage: select, round and saturate
    logic [AngW-1:0]  turn_w;
    logic [33:0]      spd_w;
    logic [14:0]      fwd_reg, turn_reg;
    assign turn_w = (mag_reg + AngW'(8)) >> 4;
    assign spd_w  = (34'(prod_reg) + 34'd2048) >> 12;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_reg  <= '0;
            turn_reg <= '0;
            if (e_reg.d2 > NearD2)
            begin
                if (mag_reg > TurnMin)
                    turn_reg <= (turn_w > AngW'(32767)) ? 15'h7FFF : turn_w[14:0];
                else
                    fwd_reg <= (spd_w > 34'(speed_limit_reg)) ? speed_limit_reg
                                                               : spd_w[14:0];
            end
        end
    end

    assign fwd_speed = fwd_reg;
    assign turn_rate = turn_reg;

    // Assertions
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fwd_speed == '0 || turn_rate == '0))
        else $error("speed and turn both non-zero");
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fwd_speed <= speed_limit_reg))
        else $error("speed above limit");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(fwd_speed))
        else $error("held item changed");

endmodule

/* bench/gtg_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gtg_checker
// Watches the pose and velocity channels and the register port, predicts
// each velocity item from the pose item and compares them field by field.
// ----------------------------------------------------------------------------
module gtg_checker
    import gtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic signed [15:0]   pos_x,
    input  logic signed [15:0]   pos_y,
    input  logic signed [15:0]   heading,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [14:0]          fwd_speed,
    input  logic [14:0]          turn_rate,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [14:0] speed;
        logic [14:0] turn;
    } velocity_t;

    logic [14:0] goal_x, goal_y, speed_limit;
    logic [15:0] speed_gain;
    velocity_t   velocity_q[$];

    // Arithmetic shift right, toward minus infinity
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        return r;
    endfunction

    // Bearing in 2^-16 rad by vectoring CORDIC
    function automatic longint bearing(longint y, longint x);
        longint z, t, xs, ys;
        longint atan_k[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 102944;
            end
            else
            begin
                x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_k[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_k[i];
            end
        end
        return z;
    endfunction

    function automatic velocity_t predict_velocity(logic signed [15:0] px,
            logic signed [15:0] py, logic signed [15:0] hd);
        longint dx, dy, d2, err, mag, spd, trn;
        velocity_t v;
        dx  = longint'(goal_x) - longint'(px);
        dy  = longint'(goal_y) - longint'(py);
        d2  = dx * dx + dy * dy;
        spd = 0;
        trn = 0;
        if (d2 > 41943)
        begin
            err = bearing(dy, dx) - longint'(hd) * 8;
            mag = err < 0 ? -err : err;
            if (mag > 13107)
            begin
                trn = (mag + 8) >> 4;
                if (trn > 32767)
                    trn = 32767;
            end
            else
                spd = (longint'(speed_gain) * root_floor(d2) + 2048) >> 12;
        end
        if (spd > longint'(speed_limit))
            spd = speed_limit;
        v.speed = spd[14:0];
        v.turn  = trn[14:0];
        return v;
    endfunction

    assign pending = velocity_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        velocity_t want;
        int        errs;
        if (!rst_n)
        begin
            goal_x      <= 15'd2048;
            goal_y      <= 15'd2048;
            speed_gain  <= 16'd4096;
            speed_limit <= 15'd6144;
            fail_count  <= 0;
            velocity_q.delete();
        end
        else
        begin
            errs = 0;
            // Results first, then new predictions with the current registers
            if (out_valid && out_ready)
            begin
                if (velocity_q.size() == 0)
                begin
                    $error("velocity item with nothing expected");
                    errs++;
                end
                else
                begin
                    want = velocity_q.pop_front();
                    if (want.speed !== fwd_speed)
                    begin
                        $error("fwd_speed expected %0d got %0d", want.speed, fwd_speed);
                        errs++;
                    end
                    if (want.turn !== turn_rate)
                    begin
                        $error("turn_rate expected %0d got %0d", want.turn, turn_rate);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (in_valid && in_ready)
                velocity_q.push_back(predict_velocity(pos_x, pos_y, heading));
            if (cfg_we)
            begin
                case (cfg_index)
                    RegGoalX:      goal_x      <= cfg_data[14:0];
                    RegGoalY:      goal_y      <= cfg_data[14:0];
                    RegSpeedGain:  speed_gain  <= cfg_data;
                    RegSpeedLimit: speed_limit <= cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives pose items and register settings into the go-to-goal block with
// random idling on both channels; the checker judges every velocity item.
// ----------------------------------------------------------------------------
module tb;
    import gtg_pkg::*;

    localparam int Latency   = 22;
    localparam int StallCap  = 4000;

    logic clk, rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] pos_x, pos_y, heading;
    logic [14:0] fwd_speed, turn_rate;
    int fail_count, pending;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    int quiet_cycles;

    go_to_goal_velocity dut (.*);

    gtg_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > StallCap)
            begin
                $display("go_to_goal_velocity test failed");
                $finish;
            end
        end
    end

    // One register write, then cfg_we low again before the task returns
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Valid stays high between back-to-back items; it drops only to idle
    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
            logic signed [15:0] hd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= px;
        pos_y    <= py;
        heading  <= hd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Mostly poses near the goal so both driving and turning are reached
    task automatic send_random(int n);
        logic signed [15:0] px, py, hd;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    px = 16'($urandom); py = 16'($urandom); hd = 16'($urandom);
                end
                default:
                begin
                    px = 16'($signed($urandom_range(12000)) - 2000);
                    py = 16'($signed($urandom_range(12000)) - 2000);
                    hd = 16'($signed($urandom_range(51472)) - 25736);
                end
            endcase
            send_pose(px, py, hd);
        end
    endtask

    task automatic settle;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (Latency + 4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; pos_x = '0; pos_y = '0; heading = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0; quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, extremes, at goal, turning, driving
        send_pose(16'sd2048, 16'sd2048, 16'sd0);
        send_pose(16'sd2100, 16'sd2048, 16'sd0);
        send_pose(16'sd0, 16'sd2048, 16'sd0);
        send_pose(16'sd4096, 16'sd2048, 16'sd0);
        send_pose(16'sd2048, 16'sd0, 16'sd12868);
        send_pose(16'sd2048, 16'sd4096, -16'sd12868);
        send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pose(16'sd32767, 16'sd32767, 16'sd32767);
        send_pose(16'sd32767, -16'sd32768, 16'sd0);
        send_pose(-16'sd32768, 16'sd32767, 16'sd25736);
        send_pose(-16'sd1, -16'sd1, -16'sd1);
        send_pose(16'sd2048, 16'sd2049, 16'sd0);
        settle();

        // Extreme registers, out-of-range goal and an ignored-free index sweep
        write_reg(RegGoalX, 16'hFFFF);
        write_reg(RegGoalY, 16'h0000);
        write_reg(RegSpeedGain, 16'hFFFF);
        write_reg(RegSpeedLimit, 16'h7FFF);
        send_pose(16'sd0, 16'sd0, 16'sd0);
        send_pose(-16'sd32768, 16'sd0, 16'sd0);
        send_pose(16'sd32767, 16'sd0, 16'sd25736);
        send_pose(16'sd0, 16'sd32767, -16'sd12868);
        settle();

        // Random phases over several settings and idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(RegGoalX, ph == 0 ? 16'd1 : 16'($urandom_range(1, 24575)));
            write_reg(RegGoalY, ph == 0 ? 16'd24575 : 16'($urandom_range(1, 24575)));
            write_reg(RegSpeedGain, ph == 1 ? 16'd0 : 16'($urandom));
            write_reg(RegSpeedLimit, ph == 1 ? 16'd0 : 16'($urandom_range(32767)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (ph == 2)
            begin
                // Long receiver hold-off so the pipeline fills and stalls input
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    send_random(200);
                join
            end
            else
                send_random(200);
            settle();
        end

        if (fail_count == 0)
            $display("go_to_goal_velocity test passed");
        else
            $display("go_to_goal_velocity test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/gtg_pkg.sv
rtl/gtg_cordic.sv
rtl/gtg_isqrt.sv
rtl/go_to_goal_velocity.sv
bench/gtg_checker.sv
bench/tb.sv
